// ----- design/wsfp_pkg.sv -----
// Shared types and constants of the WebSocket frame parser.
package wsfp_pkg;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    EV_BYTE   = 2'd0,
    EV_EMPTY  = 2'd1,
    EV_REJECT = 2'd2
  } event_e;

  // Parser phases
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_EXTLEN = 2'd1,
    PH_MASK   = 2'd2,
    PH_DATA   = 2'd3
  } phase_e;

  // Header field codes and limits
  localparam logic [6:0]  LEN_EXT16     = 7'd126;
  localparam logic [6:0]  LEN_EXT64     = 7'd127;
  localparam logic [1:0]  KEY_LAST_POS  = 2'd3;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  // Command passed from the header parser to the output stage
  typedef struct packed {
    event_e      ev;
    logic [7:0]  raw_byte;
    logic [7:0]  key_byte;
    logic [15:0] index;
    logic [3:0]  opcode;
    logic        fin;
    logic [15:0] length;
    logic        last;
  } cmd_t;

endpackage

// ----- design/wsfp_byte_if.sv -----
// Input channel carrying one raw stream byte per beat.
interface wsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- design/wsfp_event_if.sv -----
// Output channel carrying one parser result per beat.
interface wsfp_event_if;
  import wsfp_pkg::*;

  logic        valid;
  logic        ready;
  event_e      event_res;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [3:0]  frame_opcode;
  logic        frame_fin;
  logic [15:0] frame_length;
  logic        last_of_frame;

  modport source (output valid, output event_res, output payload_byte, output payload_index,
                  output frame_opcode, output frame_fin, output frame_length,
                  output last_of_frame, input ready);
  modport sink   (input valid, input event_res, input payload_byte, input payload_index,
                  input frame_opcode, input frame_fin, input frame_length,
                  input last_of_frame, output ready);
endinterface

// ----- design/websocket_frame_parser.sv -----
// Top level of the WebSocket frame parser.
// Usage:
//   in_i carries one raw stream byte per beat (valid/ready). Header, length
//   and mask-key bytes are consumed silently; each payload byte yields one
//   beat on out_o with the unmasked byte, its index and a last flag. An
//   empty frame yields one completion beat, a 64-bit length or an extended
//   length above the limit yields one reject beat; the parser then expects
//   the next frame header.
//   cfg_we_i/cfg_data_i write the extended-length limit (reset 4096); write
//   it only while no frame is in flight.
// Timing:
//   One byte per cycle while the command queue has room. A result reaches out_o
//   via the command queue: the accepting edge writes it into the queue, and it
//   moves on into the output register once that register is empty or its beat
//   leaves. The parser state advances once per accepted byte.
// Stall and reset:
//   When out_o stalls, the output register holds its beat, the queue fills
//   (QUEUE_DEPTH entries) and in_i.ready drops only once the queue is full.
//   Reset empties queue and output register and returns to header parsing.
module websocket_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsfp_byte_if.sink    in_i,
  wsfp_event_if.source out_o,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_data_i
);
  import wsfp_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_push, q_full, q_valid, back_pop;

  wsfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .full_i     (q_full),
    .push_o     (front_push),
    .cmd_o      (front_cmd)
  );

  wsfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  wsfp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (back_cmd),
    .pop_o   (back_pop),
    .out_o   (out_o)
  );

endmodule

// ----- design/wsfp_front.sv -----
// Header parser: tracks frame state per byte and issues result commands.
module wsfp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  wsfp_byte_if.sink       in_i,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            full_i,
  output logic            push_o,
  output wsfp_pkg::cmd_t  cmd_o
);
  import wsfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic        fin_q, fin_d;
  logic [3:0]  opc_q, opc_d;
  logic        masked_q, masked_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [15:0] max_q;
  logic [7:0]  key_q [4];

  logic        take;
  logic        done;
  logic [7:0]  b;
  logic [6:0]  plen;
  logic [15:0] ext_len;
  logic [15:0] count_inc;

  assign in_i.ready = !full_i;
  assign take       = in_i.valid && !full_i;
  assign b          = in_i.data_byte;
  assign plen       = b[6:0];
  assign ext_len    = {len_q[15:8], b};
  assign count_inc  = count_q + 16'd1;

  // Classify the byte and build the command for the output stage
  always_comb begin : classify
    push_o           = 1'b0;
    done             = 1'b0;
    cmd_o            = '0;
    cmd_o.ev         = EV_BYTE;
    cmd_o.opcode     = opc_q;
    cmd_o.fin        = fin_q;
    if (take) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q != 2'd0) begin
            if (plen == LEN_EXT64) begin
              push_o   = 1'b1;
              done     = 1'b1;
              cmd_o.ev = EV_REJECT;
            end else if (plen == 7'd0 && !b[7]) begin
              push_o     = 1'b1;
              done       = 1'b1;
              cmd_o.ev   = EV_EMPTY;
              cmd_o.last = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          if (pos_q != 2'd0) begin
            if (ext_len > max_q) begin
              push_o       = 1'b1;
              done         = 1'b1;
              cmd_o.ev     = EV_REJECT;
              cmd_o.length = ext_len;
            end else if (ext_len == 16'd0 && !masked_q) begin
              push_o     = 1'b1;
              done       = 1'b1;
              cmd_o.ev   = EV_EMPTY;
              cmd_o.last = 1'b1;
            end
          end
        end
        PH_MASK: begin
          if (pos_q == KEY_LAST_POS && len_q == 16'd0) begin
            push_o     = 1'b1;
            done       = 1'b1;
            cmd_o.ev   = EV_EMPTY;
            cmd_o.last = 1'b1;
          end
        end
        PH_DATA: begin
          push_o         = 1'b1;
          done           = count_inc >= len_q;
          cmd_o.raw_byte = b;
          cmd_o.key_byte = masked_q ? key_q[count_q[1:0]] : 8'h00;
          cmd_o.index    = count_q;
          cmd_o.length   = len_q;
          cmd_o.last     = count_inc >= len_q;
        end
        default: ;
      endcase
    end
  end

  // Advance the frame state; a finished or rejected frame clears it
  always_comb begin : next_state
    phase_d  = phase_q;
    pos_d    = pos_q;
    fin_d    = fin_q;
    opc_d    = opc_q;
    masked_d = masked_q;
    len_d    = len_q;
    count_d  = count_q;
    if (take) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q == 2'd0) begin
            fin_d = b[7];
            opc_d = b[3:0];
            pos_d = 2'd1;
          end else begin
            masked_d = b[7];
            pos_d    = 2'd0;
            count_d  = '0;
            if (plen == LEN_EXT16) begin
              len_d   = '0;
              phase_d = PH_EXTLEN;
            end else begin
              len_d   = {9'd0, plen};
              phase_d = b[7] ? PH_MASK : PH_DATA;
            end
          end
        end
        PH_EXTLEN: begin
          if (pos_q == 2'd0) begin
            len_d = {b, 8'h00};
            pos_d = 2'd1;
          end else begin
            len_d   = ext_len;
            pos_d   = 2'd0;
            count_d = '0;
            phase_d = masked_q ? PH_MASK : PH_DATA;
          end
        end
        PH_MASK: begin
          pos_d = pos_q + 2'd1;
          if (pos_q == KEY_LAST_POS) begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          count_d = count_inc;
        end
        default: ;
      endcase
      if (done) begin
        phase_d  = PH_HEADER;
        pos_d    = '0;
        fin_d    = 1'b0;
        opc_d    = '0;
        masked_d = 1'b0;
        len_d    = '0;
        count_d  = '0;
      end
    end
  end

  // Frame state and limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      fin_q    <= 1'b0;
      opc_q    <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      count_q  <= '0;
      max_q    <= MAX_LEN_RESET;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      fin_q    <= fin_d;
      opc_q    <= opc_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      count_q  <= count_d;
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  // Capture the mask key bytes
  always_ff @(posedge clk_i) begin
    if (take && phase_q == PH_MASK) begin
      key_q[pos_q] <= b;
    end
  end

endmodule

// ----- design/wsfp_queue.sv -----
// Short command queue between the header parser and the output stage.
module wsfp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wsfp_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output wsfp_pkg::cmd_t  cmd_o
);
  import wsfp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == FullCnt;
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/wsfp_back.sv -----
// Output stage: unmasks payload bytes and holds the result register.
module wsfp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  wsfp_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  wsfp_event_if.source    out_o
);
  import wsfp_pkg::*;

  logic        valid_q;
  event_e      ev_q;
  logic [7:0]  byte_q;
  logic [15:0] index_q;
  logic [3:0]  opc_q;
  logic        fin_q;
  logic [15:0] len_q;
  logic        last_q;

  // Load when the register is empty or its beat leaves this cycle
  assign pop_o = valid_i && (!valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_o.ready) begin
      valid_q <= valid_i;
    end
  end

  // Unmask and capture the result
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q    <= cmd_i.ev;
      byte_q  <= cmd_i.raw_byte ^ cmd_i.key_byte;
      index_q <= cmd_i.index;
      opc_q   <= cmd_i.opcode;
      fin_q   <= cmd_i.fin;
      len_q   <= cmd_i.length;
      last_q  <= cmd_i.last;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.event_res     = ev_q;
  assign out_o.payload_byte  = byte_q;
  assign out_o.payload_index = index_q;
  assign out_o.frame_opcode  = opc_q;
  assign out_o.frame_fin     = fin_q;
  assign out_o.frame_length  = len_q;
  assign out_o.last_of_frame = last_q;

endmodule

// ----- design/wsfp_checker.sv -----
// Port-level assertions for the frame parser, bound to the top level.
module wsfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  event_res_i,
  input logic [7:0]  payload_byte_i,
  input logic [15:0] payload_index_i,
  input logic [15:0] frame_length_i,
  input logic        last_of_frame_i
);
  import wsfp_pkg::*;

  // Reset leaves no beat on the output
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // A stalled beat stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(payload_index_i) && $stable(event_res_i))
    else $error("stalled beat changed");

  // Only payload beats carry a byte and an index
  a_nonbyte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i != EV_BYTE |->
      payload_byte_i == 8'h00 && payload_index_i == 16'h0)
    else $error("non-payload beat carries data");

  // Empty frames complete, rejects do not
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i != EV_BYTE |-> last_of_frame_i == (event_res_i == EV_EMPTY))
    else $error("wrong last flag on completion or reject");

  // The last flag marks the payload byte whose index is the declared length minus one
  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i == EV_BYTE |->
      last_of_frame_i == (({1'b0, payload_index_i} + 17'd1) >= {1'b0, frame_length_i}))
    else $error("last flag disagrees with index and length");

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .event_res_i     (out_o.event_res),
  .payload_byte_i  (out_o.payload_byte),
  .payload_index_i (out_o.payload_index),
  .frame_length_i  (out_o.frame_length),
  .last_of_frame_i (out_o.last_of_frame)
);
